// ===== src/ibfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfr_pkg
// Shared constants and codes of the serial bus frame receiver.
// ----------------------------------------------------------------------------
package ibfr_pkg;

  // Frame layout: two header bytes, channel words, two trailer bytes.
  localparam int FRAME_BYTES  = 32;
  localparam int ADDR_W       = $clog2(FRAME_BYTES);
  localparam int CHANNELS_DEF = 14;

  localparam logic [ADDR_W-1:0] TRAILER_LO_ADDR = ADDR_W'(FRAME_BYTES - 2);
  localparam logic [ADDR_W-1:0] LAST_ADDR       = ADDR_W'(FRAME_BYTES - 1);

  localparam logic [7:0] HDR0 = 8'h20;
  localparam logic [7:0] HDR1 = 8'h40;

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 4;
  localparam int WORD_W  = 16;
  localparam int TOTAL_W = 32;
  localparam int GAP_W   = 8;
  localparam int MS_W    = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = 2'd1;

  localparam logic [GAP_W-1:0] FRAME_GAP_RST    = 8'd3;
  localparam logic [MS_W-1:0]  LINK_TIMEOUT_RST = 16'd100;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result item kinds.
  localparam logic RES_CHANNEL   = 1'b0;
  localparam logic RES_LINK_LOST = 1'b1;

endpackage

// ===== src/ibfr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfr_in_if
// Input channel: received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface ibfr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ibfr_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, output kind, output byte_value, input ready);
  modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

// ===== src/ibfr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfr_out_if
// Result channel: channel words of good frames and link-lost events.
// ----------------------------------------------------------------------------
interface ibfr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           result_kind;
  logic [ibfr_pkg::IDX_W-1:0]     channel_index;
  logic [ibfr_pkg::WORD_W-1:0]    channel_value;
  logic [ibfr_pkg::TOTAL_W-1:0]   frame_total;
  logic                           link_up;
  logic                           last;

  modport source (output valid, output result_kind, output channel_index,
                  output channel_value, output frame_total, output link_up,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input channel_index,
                  input channel_value, input frame_total, input link_up,
                  input last, output ready);
endinterface

// ===== src/ibfr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ibfr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ibfr_pkg::CFG_IDX_W-1:0]    index;
  logic [ibfr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ibus_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_frame_receiver
// Collects 32-byte servo bus frames, checks them and emits channel words and link-lost events.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: a received byte (kind 0) or a
//   millisecond tick (kind 1). out_ch carries channel words of good frames,
//   with last set on the final channel, and link-lost events. cfg_ch writes
//   register 0 (frame gap in ms) and register 1 (link timeout in ms); it is
//   always ready.
//   A tick that times out the link loads its event into the output register
//   in the cycle in which it is taken. The byte that completes a good frame
//   starts a burst: each channel word takes two reads of the frame memory
//   (one read port, registered) and one load of the output register, and
//   no input item is taken while the burst of 14 words runs.
//   After reset no partial frame is held, the link is down, the counters
//   are zero and the registers hold 3 ms and 100 ms. When the receiver
//   stalls, the result waits in the output register, no input item is
//   taken until that register is free, and a burst holds at its word.
// ----------------------------------------------------------------------------
module ibus_frame_receiver #(
  parameter int CHANNELS = ibfr_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ibfr_in_if.sink       in_ch,
  ibfr_out_if.source    out_ch,
  ibfr_cfg_if.sink      cfg_ch
);

  localparam int AW = ibfr_pkg::ADDR_W;
  localparam logic [ibfr_pkg::IDX_W-1:0] LAST_CH = ibfr_pkg::IDX_W'(CHANNELS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RDLO, S_RDHI, S_WORD} state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   count_r, count_nxt;
  logic [15:0]                     sum_r, sum_nxt;
  logic [ibfr_pkg::MS_W-1:0]       ms_byte_r, ms_byte_nxt;
  logic [ibfr_pkg::MS_W-1:0]       ms_frame_r, ms_frame_nxt;
  logic                            link_r, link_nxt;
  logic [ibfr_pkg::TOTAL_W-1:0]    good_r, good_nxt;
  logic [7:0]                      b30_r, b30_nxt;
  logic [7:0]                      lo_r, lo_nxt;
  logic [ibfr_pkg::IDX_W-1:0]      ch_r, ch_nxt;
  logic [ibfr_pkg::GAP_W-1:0]      gap_r, gap_nxt;
  logic [ibfr_pkg::MS_W-1:0]       timeout_r, timeout_nxt;

  // Output register.
  logic                            ovalid_r, ovalid_nxt;
  logic                            okind_r, okind_nxt;
  logic [ibfr_pkg::IDX_W-1:0]      oidx_r, oidx_nxt;
  logic [ibfr_pkg::WORD_W-1:0]     oval_r, oval_nxt;
  logic [ibfr_pkg::TOTAL_W-1:0]    ototal_r, ototal_nxt;
  logic                            oup_r, oup_nxt;
  logic                            olast_r, olast_nxt;

  // Frame memory.
  logic [7:0]                      mem [ibfr_pkg::FRAME_BYTES];
  logic [7:0]                      rd_data_r;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   wr_addr;
  logic                            mem_we;
  logic [AW-1:0]                   lo_addr;
  logic [AW-1:0]                   hi_addr;

  logic                            out_free;
  logic                            in_fire;

  assign out_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Channel i sits at bytes 2 + 2i (low) and 3 + 2i (high).
  assign lo_addr = AW'({ch_r, 1'b0}) + AW'(2);
  assign hi_addr = lo_addr + AW'(1);

  assign out_ch.valid         = ovalid_r;
  assign out_ch.result_kind   = okind_r;
  assign out_ch.channel_index = oidx_r;
  assign out_ch.channel_value = oval_r;
  assign out_ch.frame_total   = ototal_r;
  assign out_ch.link_up       = oup_r;
  assign out_ch.last          = olast_r;

  // Next-state logic for frame assembly, link aging and the channel burst.
  always_comb begin
    logic [AW-1:0]             held;
    logic [15:0]               sum_v;
    logic                      take;
    logic [ibfr_pkg::MS_W-1:0] msf_v;

    state_nxt    = state_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    ms_byte_nxt  = ms_byte_r;
    ms_frame_nxt = ms_frame_r;
    link_nxt     = link_r;
    good_nxt     = good_r;
    b30_nxt      = b30_r;
    lo_nxt       = lo_r;
    ch_nxt       = ch_r;
    gap_nxt      = gap_r;
    timeout_nxt  = timeout_r;
    ovalid_nxt   = ovalid_r && !out_ch.ready;
    okind_nxt    = okind_r;
    oidx_nxt     = oidx_r;
    oval_nxt     = oval_r;
    ototal_nxt   = ototal_r;
    oup_nxt      = oup_r;
    olast_nxt    = olast_r;
    mem_we       = 1'b0;
    wr_addr      = count_r;
    rd_addr      = lo_addr;
    held         = count_r;
    sum_v        = sum_r;
    take         = 1'b0;
    msf_v        = ms_frame_r;

    // Register writes.
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ibfr_pkg::REG_FRAME_GAP:    gap_nxt = cfg_ch.data[ibfr_pkg::GAP_W-1:0];
        ibfr_pkg::REG_LINK_TIMEOUT: timeout_nxt = cfg_ch.data[ibfr_pkg::MS_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.kind == ibfr_pkg::KIND_TICK) begin
          // Tick: age both counters, saturating, and check the link.
          if (ms_byte_r != '1) ms_byte_nxt = ms_byte_r + 1'b1;
          if (ms_frame_r != '1) msf_v = ms_frame_r + 1'b1;
          ms_frame_nxt = msf_v;
          if (link_r && msf_v > timeout_r) begin
            link_nxt   = 1'b0;
            ovalid_nxt = 1'b1;
            okind_nxt  = ibfr_pkg::RES_LINK_LOST;
            oidx_nxt   = '0;
            oval_nxt   = '0;
            ototal_nxt = good_r;
            oup_nxt    = 1'b0;
            olast_nxt  = 1'b1;
          end
        end else if (in_fire) begin
          // Byte: a long gap drops a partial frame first.
          if (held != '0 && ms_byte_r >= ibfr_pkg::MS_W'(gap_r)) begin
            held  = '0;
            sum_v = '0;
          end
          ms_byte_nxt = '0;
          take = 1'b1;
          if (held == AW'(0) && in_ch.byte_value != ibfr_pkg::HDR0) take = 1'b0;
          if (held == AW'(1) && in_ch.byte_value != ibfr_pkg::HDR1) begin
            take  = 1'b0;
            held  = '0;
            sum_v = '0;
          end
          if (take) begin
            mem_we  = 1'b1;
            wr_addr = held;
            if (held < ibfr_pkg::TRAILER_LO_ADDR) sum_v = sum_v + 16'(in_ch.byte_value);
            if (held == ibfr_pkg::TRAILER_LO_ADDR) b30_nxt = in_ch.byte_value;
            if (held == ibfr_pkg::LAST_ADDR) begin
              // Full frame: trailer must equal 0xFFFF minus the sum.
              if ({in_ch.byte_value, b30_r} == ~sum_v) begin
                good_nxt     = good_r + 1'b1;
                link_nxt     = 1'b1;
                ms_frame_nxt = '0;
                ch_nxt       = '0;
                state_nxt    = S_RDLO;
              end
              held  = '0;
              sum_v = '0;
            end else begin
              held = held + 1'b1;
            end
          end
          count_nxt = held;
          sum_nxt   = sum_v;
        end
      end
      S_RDLO: begin
        rd_addr   = lo_addr;
        state_nxt = S_RDHI;
      end
      S_RDHI: begin
        rd_addr   = hi_addr;
        lo_nxt    = rd_data_r;
        state_nxt = S_WORD;
      end
      S_WORD: begin
        // The high byte stays on the read port until the word is loaded.
        rd_addr = hi_addr;
        if (out_free) begin
          ovalid_nxt = 1'b1;
          okind_nxt  = ibfr_pkg::RES_CHANNEL;
          oidx_nxt   = ch_r;
          oval_nxt   = {rd_data_r, lo_r};
          ototal_nxt = good_r;
          oup_nxt    = 1'b1;
          olast_nxt  = (ch_r == LAST_CH);
          if (ch_r == LAST_CH) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_RDLO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      sum_r      <= '0;
      ms_byte_r  <= '0;
      ms_frame_r <= '0;
      link_r     <= 1'b0;
      good_r     <= '0;
      ch_r       <= '0;
      gap_r      <= ibfr_pkg::FRAME_GAP_RST;
      timeout_r  <= ibfr_pkg::LINK_TIMEOUT_RST;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      ms_byte_r  <= ms_byte_nxt;
      ms_frame_r <= ms_frame_nxt;
      link_r     <= link_nxt;
      good_r     <= good_nxt;
      ch_r       <= ch_nxt;
      gap_r      <= gap_nxt;
      timeout_r  <= timeout_nxt;
      ovalid_r   <= ovalid_nxt;
    end
    b30_r    <= b30_nxt;
    lo_r     <= lo_nxt;
    okind_r  <= okind_nxt;
    oidx_r   <= oidx_nxt;
    oval_r   <= oval_nxt;
    ototal_r <= ototal_nxt;
    oup_r    <= oup_nxt;
    olast_r  <= olast_nxt;
  end

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_ch.byte_value;
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ===== sim/tb_ibus_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ibus_frame_receiver
// Self-checking bench for the servo bus frame receiver. A short table of
// directed steps covers the byte extremes, header and checksum errors, gap
// drops, register writes and link loss. A random part follows with mostly
// well-formed frames mixed with noise and broken frames. Every result item
// is checked against a cycle-free model of the receiver, with random idle
// cycles on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_ibus_frame_receiver;

  localparam int N_CH   = ibfr_pkg::CHANNELS_DEF;
  localparam int FB     = ibfr_pkg::FRAME_BYTES;
  localparam int SETTLE = 64;
  localparam int LIMIT  = 200_000;
  localparam int ITEMS  = 120;

  localparam logic [ibfr_pkg::WORD_W-1:0]    SUM_BASE   = 16'hFFFF;
  localparam logic [ibfr_pkg::MS_W-1:0]      MS_SAT     = 16'hFFFF;
  localparam logic [ibfr_pkg::CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [ibfr_pkg::CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  typedef enum logic [2:0] {
    OP_TICKS, OP_BYTE, OP_FRAME, OP_BAD_FRAME, OP_PARTIAL, OP_CFG, OP_CFG2
  } step_op_t;

  // One directed step. For frames a is the fill, b the byte position where
  // ticks are slipped in and c their number. A hand-typed step expects no
  // result, or exactly one link-lost item with the given frame total.
  typedef struct packed {
    step_op_t    op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        typed;
    logic        lost;
    logic [31:0] total;
  } step_t;

  typedef struct packed {
    logic                         result_kind;
    logic [ibfr_pkg::IDX_W-1:0]   channel_index;
    logic [ibfr_pkg::WORD_W-1:0]  channel_value;
    logic [ibfr_pkg::TOTAL_W-1:0] frame_total;
    logic                         link_up;
    logic                         last;
  } rx_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;

  ibfr_in_if  in_ch();
  ibfr_out_if out_ch();
  ibfr_cfg_if cfg_ch();

  assign out_ch.ready = sink_ready;

  ibus_frame_receiver #(.CHANNELS(N_CH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Model state of the receiver.
  logic [ibfr_pkg::BYTE_W-1:0]  m_frame [FB];
  logic [5:0]                   m_held;
  logic [ibfr_pkg::WORD_W-1:0]  m_sum;
  logic [ibfr_pkg::MS_W-1:0]    m_ms_byte;
  logic [ibfr_pkg::MS_W-1:0]    m_ms_frame;
  logic                         m_link;
  logic [ibfr_pkg::TOTAL_W-1:0] m_frames;
  logic [ibfr_pkg::GAP_W-1:0]   m_gap;
  logic [ibfr_pkg::MS_W-1:0]    m_timeout;

  rx_result_t  decoded_q [$];
  logic [7:0]  frame_buf [FB];
  bit          hand_typed = 1'b0;
  bit          calm = 1'b0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          stall_left = 0;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_result(logic kind, logic [ibfr_pkg::IDX_W-1:0] idx,
                                      logic [ibfr_pkg::WORD_W-1:0] val, logic up,
                                      logic lst);
    if (!hand_typed)
      decoded_q.push_back('{kind, idx, val, m_frames, up, lst});
  endfunction

  // Advance the model by one accepted input item and queue its results.
  function automatic void decode_rx_item(logic kind, logic [ibfr_pkg::BYTE_W-1:0] b);
    logic [ibfr_pkg::WORD_W-1:0] trailer;
    logic                        sum_ok;
    if (kind == ibfr_pkg::KIND_TICK) begin
      if (m_ms_byte != MS_SAT) m_ms_byte++;
      if (m_ms_frame != MS_SAT) m_ms_frame++;
      if (m_link && m_ms_frame > m_timeout) begin
        m_link = 1'b0;
        note_result(ibfr_pkg::RES_LINK_LOST, '0, '0, 1'b0, 1'b1);
      end
      return;
    end

    // A long enough silence drops whatever partial frame is held.
    if (m_held != '0 && m_ms_byte >= ibfr_pkg::MS_W'(m_gap)) begin
      m_held = '0;
      m_sum  = '0;
    end
    m_ms_byte = '0;

    if (m_held == 6'd0 && b != ibfr_pkg::HDR0) return;
    if (m_held == 6'd1 && b != ibfr_pkg::HDR1) begin
      m_held = '0;
      m_sum  = '0;
      return;
    end
    if (m_held >= 6'(FB)) begin
      m_held = '0;
      m_sum  = '0;
      return;
    end

    m_frame[m_held[ibfr_pkg::ADDR_W-1:0]] = b;
    if (m_held < 6'(FB - 2)) m_sum = m_sum + ibfr_pkg::WORD_W'(b);
    m_held++;
    if (m_held < 6'(FB)) return;

    trailer = {m_frame[ibfr_pkg::LAST_ADDR], m_frame[ibfr_pkg::TRAILER_LO_ADDR]};
    sum_ok  = (trailer == SUM_BASE - m_sum);
    m_held  = '0;
    m_sum   = '0;
    if (!sum_ok) return;

    m_frames   = m_frames + 32'd1;
    m_link     = 1'b1;
    m_ms_frame = '0;
    for (int i = 0; i < N_CH; i++)
      note_result(ibfr_pkg::RES_CHANNEL, ibfr_pkg::IDX_W'(i),
                  {m_frame[3 + 2 * i], m_frame[2 + 2 * i]}, 1'b1, (i == N_CH - 1));
  endfunction

  // Present one input item and hold it until the receiver takes it.
  task automatic send_item(logic kind, logic [ibfr_pkg::BYTE_W-1:0] b);
    int idle;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    decode_rx_item(kind, b);
    items_sent++;
    idle = pick_idle();
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(ibfr_pkg::KIND_TICK, 8'($urandom));
  endtask

  // Build a frame and send its first nbytes bytes, slipping split_ticks
  // ticks in just before byte split_at when that position is nonzero.
  task automatic send_frame(fill_t fill, bit good, int split_at, int split_ticks,
                            int nbytes);
    logic [ibfr_pkg::WORD_W-1:0] sum;
    logic [ibfr_pkg::WORD_W-1:0] trailer;
    frame_buf[0] = ibfr_pkg::HDR0;
    frame_buf[1] = ibfr_pkg::HDR1;
    for (int i = 2; i < FB - 2; i++) begin
      case (fill)
        FILL_ZERO: frame_buf[i] = 8'h00;
        FILL_ONES: frame_buf[i] = 8'hFF;
        default:   frame_buf[i] = 8'($urandom);
      endcase
    end
    sum = '0;
    for (int i = 0; i < FB - 2; i++) sum = sum + ibfr_pkg::WORD_W'(frame_buf[i]);
    trailer = SUM_BASE - sum;
    frame_buf[FB - 2] = trailer[7:0];
    frame_buf[FB - 1] = trailer[15:8];
    if (!good) frame_buf[FB - 2] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < nbytes; i++) begin
      if (split_at > 0 && i == split_at) send_ticks(split_ticks);
      send_item(ibfr_pkg::KIND_BYTE, frame_buf[i]);
    end
  endtask

  // Register write, only once the receiver has gone quiet.
  task automatic write_reg(logic [ibfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [ibfr_pkg::CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == ibfr_pkg::REG_FRAME_GAP) m_gap = val[ibfr_pkg::GAP_W-1:0];
    else if (idx == ibfr_pkg::REG_LINK_TIMEOUT) m_timeout = val;
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Result side: random stalls.
  always @(posedge clk) begin
    int n;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else begin
      n = pick_idle();
      if (n > 0) begin
        stall_left <= n - 1;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $error("unexpected result item: kind %0d index %0d value %0h",
               out_ch.result_kind, out_ch.channel_index, out_ch.channel_value);
      end else begin
        want = decoded_q.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(out_ch.result_kind));
        check_field("channel_index", 32'(want.channel_index), 32'(out_ch.channel_index));
        check_field("channel_value", 32'(want.channel_value), 32'(out_ch.channel_value));
        check_field("frame_total", want.frame_total, out_ch.frame_total);
        check_field("link_up", 32'(want.link_up), 32'(out_ch.link_up));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Directed steps, starting from the reset settings of 3 ms and 100 ms.
  step_t plan [$] = '{
    '{OP_TICKS,     32'd1,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_BYTE,      32'h00,                            32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_BYTE,      32'hFF,                            32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_BYTE,      32'(ibfr_pkg::HDR0),               32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_BYTE,      32'(ibfr_pkg::HDR0),               32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_PARTIAL,   32'd4,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_TICKS,     32'd3,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_FRAME,     32'(FILL_ONES),                    32'd0,     32'd0,
      1'b0, 1'b0, 32'd0},
    '{OP_BAD_FRAME, 32'(FILL_ZERO),                    32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_PARTIAL,   32'd3,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_TICKS,     32'd3,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_CFG,       32'(ibfr_pkg::REG_LINK_TIMEOUT),   32'd0,     32'd0,
      1'b0, 1'b0, 32'd0},
    '{OP_TICKS,     32'd1,                             32'd0,     32'd0,
      1'b1, 1'b1, 32'd1},
    '{OP_TICKS,     32'd1,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_CFG,       32'(ibfr_pkg::REG_FRAME_GAP),      32'hFF00,  32'd0,
      1'b0, 1'b0, 32'd0},
    '{OP_PARTIAL,   32'd3,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0},
    '{OP_CFG,       32'(REG_SPARE2),                   32'hFFFF,  32'd0,
      1'b0, 1'b0, 32'd0},
    '{OP_CFG,       32'(REG_SPARE3),                   32'h1234,  32'd0,
      1'b0, 1'b0, 32'd0},
    '{OP_CFG2,      32'd255,                           32'd65535, 32'd0,
      1'b0, 1'b0, 32'd0},
    '{OP_TICKS,     32'd1,                             32'd0,     32'd0,
      1'b1, 1'b0, 32'd0}
  };

  initial begin
    step_t step;
    int    gap_ms;
    int    tmo_ms;
    int    rand_frames;
    int    r;
    int    pos;
    int    n;

    // Known values on every input from time zero, with reset asserted.
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = ibfr_pkg::KIND_BYTE;
    in_ch.byte_value = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = ibfr_pkg::REG_FRAME_GAP;
    cfg_ch.data      = '0;

    foreach (m_frame[i]) m_frame[i] = '0;
    m_held     = '0;
    m_sum      = '0;
    m_ms_byte  = '0;
    m_ms_frame = '0;
    m_link     = 1'b0;
    m_frames   = '0;
    m_gap      = ibfr_pkg::FRAME_GAP_RST;
    m_timeout  = ibfr_pkg::LINK_TIMEOUT_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (plan[i]) begin
      step       = plan[i];
      hand_typed = step.typed;
      if (step.typed && step.lost)
        decoded_q.push_back('{ibfr_pkg::RES_LINK_LOST, '0, '0, step.total, 1'b0, 1'b1});
      case (step.op)
        OP_TICKS:     send_ticks(step.a);
        OP_BYTE:      send_item(ibfr_pkg::KIND_BYTE, step.a[7:0]);
        OP_FRAME:     send_frame(fill_t'(step.a[1:0]), 1'b1, step.b, step.c, FB);
        OP_BAD_FRAME: send_frame(fill_t'(step.a[1:0]), 1'b0, 0, 0, FB);
        OP_PARTIAL:   send_frame(FILL_RANDOM, 1'b1, 0, 0, step.a);
        OP_CFG:       write_reg(step.a[ibfr_pkg::CFG_IDX_W-1:0],
                                step.b[ibfr_pkg::CFG_DATA_W-1:0]);
        default: begin
          write_reg(ibfr_pkg::REG_FRAME_GAP, step.a[ibfr_pkg::CFG_DATA_W-1:0]);
          write_reg(ibfr_pkg::REG_LINK_TIMEOUT, step.b[ibfr_pkg::CFG_DATA_W-1:0]);
        end
      endcase
      hand_typed = 1'b0;
    end

    // Random part: short gap and timeout so that drops and link loss occur,
    // with stretches of back-to-back items.
    gap_ms = $urandom_range(1, 8);
    tmo_ms = $urandom_range(1, 8);
    write_reg(ibfr_pkg::REG_FRAME_GAP, ibfr_pkg::CFG_DATA_W'(gap_ms));
    write_reg(ibfr_pkg::REG_LINK_TIMEOUT, ibfr_pkg::CFG_DATA_W'(tmo_ms));
    rand_frames = 0;
    while (items_sent < ITEMS || rand_frames < 1) begin
      calm = ($urandom_range(0, 3) == 0);
      r    = $urandom_range(0, 99);
      if (r < 50) begin
        // Well-formed frame, usually after flushing a stray partial one.
        if (m_held != '0 && $urandom_range(0, 9) < 8) send_ticks(gap_ms);
        pos = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 31) : 0;
        n   = (pos == 0) ? 0 : $urandom_range(0, gap_ms - 1);
        send_frame(FILL_RANDOM, 1'b1, pos, n, FB);
        rand_frames++;
      end else if (r < 60) begin
        send_frame(FILL_RANDOM, 1'b0, 0, 0, FB);
      end else if (r < 70) begin
        // A silence of at least the gap in the middle of a frame.
        send_frame(FILL_RANDOM, 1'b1, $urandom_range(1, 31),
                   $urandom_range(gap_ms, gap_ms + 2), FB);
      end else if (r < 80) begin
        // Noise with header bytes over-represented.
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       send_item(ibfr_pkg::KIND_BYTE, ibfr_pkg::HDR0);
            1:       send_item(ibfr_pkg::KIND_BYTE, ibfr_pkg::HDR1);
            default: send_item(ibfr_pkg::KIND_BYTE, 8'($urandom));
          endcase
        end
      end else begin
        send_ticks($urandom_range(1, tmo_ms + 2));
      end
    end
    calm = 1'b0;

    // Drain and let the receiver settle.
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
